// ===== design/ffst_pkg.sv =====
`default_nettype none

package ffst_pkg;

  // Fixed field widths of the request, response and configuration channels
  localparam int KIND_W       = 2;
  localparam int SLOT_INDEX_W = 6;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 7;
  localparam int CAPACITY_W   = 7;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_BAD_VALUE = 2'd3
  } status_t;

  // Control part of a request as it moves along the slot row
  typedef struct packed {
    kind_t                   kind;
    status_t                 status;
    logic                    inc;
    logic                    dec;
    logic [SLOT_INDEX_W-1:0] idx;
    logic [SLOT_INDEX_W-1:0] res_idx;
  } stage_t;

endpackage

`default_nettype wire

// ===== design/ffst_req_if.sv =====
`default_nettype none

interface ffst_req_if;
  logic                              valid;
  logic                              ready;
  logic [ffst_pkg::KIND_W-1:0]       kind;
  logic [ffst_pkg::SLOT_INDEX_W-1:0] slot_index;
  logic [ffst_pkg::VAL_W-1:0]        entry_value;

  modport source (output valid, kind, slot_index, entry_value, input ready);
  modport sink   (input valid, kind, slot_index, entry_value, output ready);
endinterface

`default_nettype wire

// ===== design/ffst_rsp_if.sv =====
`default_nettype none

interface ffst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ffst_pkg::STATUS_W-1:0]     status;
  logic [ffst_pkg::SLOT_INDEX_W-1:0] result_index;
  logic [ffst_pkg::VAL_W-1:0]        result_value;
  logic [ffst_pkg::OCC_W-1:0]        occupied;

  modport source (output valid, status, result_index, result_value, occupied, input ready);
  modport sink   (input valid, status, result_index, result_value, occupied, output ready);
endinterface

`default_nettype wire

// ===== design/ffst_cfg_if.sv =====
`default_nettype none

interface ffst_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ffst_pkg::CAPACITY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/ffst_slot.sv =====
`default_nettype none

module ffst_slot #(
  parameter int SLOT_NUM   = 0,
  parameter int VALUE_BITS = ffst_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic [CNT_W-1:0]      cap,
  input  wire logic                  in_valid,
  input  wire ffst_pkg::stage_t      in_ctl,
  input  wire logic [VALUE_BITS-1:0] in_val,
  input  wire logic [VALUE_BITS-1:0] in_res_val,
  output logic                       out_valid,
  output ffst_pkg::stage_t           out_ctl,
  output logic [VALUE_BITS-1:0]      out_val,
  output logic [VALUE_BITS-1:0]      out_res_val
);

  logic                  occ;
  logic [VALUE_BITS-1:0] slot_value;
  logic                  hit_add;
  logic                  hit_idx;
  logic                  clr;
  ffst_pkg::stage_t      ctl_next;
  logic [VALUE_BITS-1:0] res_val_next;

  // Claim this slot for a pending add, or serve a lookup or delete aimed here
  always_comb begin
    hit_add = in_valid && (in_ctl.kind == ffst_pkg::KIND_ADD)
              && (in_ctl.status == ffst_pkg::ST_FULL) && !occ && (SLOT_NUM < int'(cap));
    hit_idx = in_valid && ((in_ctl.kind == ffst_pkg::KIND_LOOKUP)
              || (in_ctl.kind == ffst_pkg::KIND_DELETE))
              && (in_ctl.status == ffst_pkg::ST_OK) && (int'(in_ctl.idx) == SLOT_NUM);
    clr = hit_idx && (in_ctl.kind == ffst_pkg::KIND_DELETE) && occ;
  end

  // Build the request handed to the next slot
  always_comb begin
    ctl_next     = in_ctl;
    res_val_next = in_res_val;
    if (hit_add) begin
      ctl_next.status  = ffst_pkg::ST_OK;
      ctl_next.res_idx = ffst_pkg::SLOT_INDEX_W'(SLOT_NUM);
      ctl_next.inc     = 1'b1;
    end
    if (hit_idx) begin
      res_val_next = occ ? slot_value : '0;
      ctl_next.dec = clr;
    end
  end

  // Slot occupancy and pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (hit_add) begin
        occ <= 1'b1;
      end else if (clr) begin
        occ <= 1'b0;
      end
    end
  end

  // Slot value and request payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (hit_add) begin
        slot_value <= in_val;
      end
      out_ctl     <= ctl_next;
      out_val     <= in_val;
      out_res_val <= res_val_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/first_free_slot_id_table_core.sv =====
// Channel  Dir  Handshake      Payload
// req      in   valid / ready  kind, slot_index, entry_value
// rsp      out  valid / ready  status, result_index, result_value, occupied
// cfg      in   valid / ready  data (capacity, 7 bits)
//
// A request passes one slot cell per cycle while no held response stalls the row; its response is
// registered through the head register, the SLOTS slot cells and the response register, and the row
// takes a new request every cycle unless stalled. The row holds SLOTS cells, each owning one slot.
// Reset clears every slot, the occupied count and the row; capacity goes to 64.
// A held response freezes the whole row; configuration writes are taken at once.
`default_nettype none

module first_free_slot_id_table_core #(
  parameter int SLOTS      = ffst_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = ffst_pkg::VALUE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffst_req_if.sink   req,
  ffst_rsp_if.source rsp,
  ffst_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int RV_W  = ffst_pkg::VAL_W;
  localparam int OC_W  = ffst_pkg::OCC_W;

  logic [ffst_pkg::CAPACITY_W-1:0] capacity;
  logic [CNT_W-1:0]                cap_eff;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  logic                            adv;

  logic                  stage_valid [SLOTS+1];
  ffst_pkg::stage_t      stage_ctl   [SLOTS+1];
  logic [VALUE_BITS-1:0] stage_val   [SLOTS+1];
  logic [VALUE_BITS-1:0] stage_rv    [SLOTS+1];

  ffst_pkg::stage_t      entry_ctl;
  logic [VALUE_BITS-1:0] entry_val;

  logic                  out_valid;
  ffst_pkg::stage_t      out_ctl;
  logic [VALUE_BITS-1:0] out_val;
  logic [CNT_W-1:0]      out_occ;

  // Capacity register, saturated to the built table size
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ffst_pkg::CAPACITY_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  assign cap_eff = (int'(capacity) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(capacity);

  // Advance the row whenever the response register is free or being drained
  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  // Classify the request on entry: bad value and bad index are settled here
  always_comb begin
    entry_val         = VALUE_BITS'(req.entry_value);
    entry_ctl.kind    = ffst_pkg::kind_t'(req.kind);
    entry_ctl.inc     = 1'b0;
    entry_ctl.dec     = 1'b0;
    entry_ctl.idx     = req.slot_index;
    entry_ctl.res_idx = req.slot_index;
    unique case (ffst_pkg::kind_t'(req.kind))
      ffst_pkg::KIND_ADD: begin
        entry_ctl.status = (entry_val == '0) ? ffst_pkg::ST_BAD_VALUE : ffst_pkg::ST_FULL;
      end
      ffst_pkg::KIND_LOOKUP, ffst_pkg::KIND_DELETE: begin
        entry_ctl.status = (int'(req.slot_index) >= int'(cap_eff)) ?
                           ffst_pkg::ST_BAD_INDEX : ffst_pkg::ST_OK;
      end
      default: begin
        entry_ctl.status = ffst_pkg::ST_OK;
      end
    endcase
  end

  // Load the head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (adv) begin
      stage_valid[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_ctl[0] <= entry_ctl;
      stage_val[0] <= entry_val;
      stage_rv[0]  <= '0;
    end
  end

  // Row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    ffst_slot #(
      .SLOT_NUM   (g),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_slot (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .cap         (cap_eff),
      .in_valid    (stage_valid[g]),
      .in_ctl      (stage_ctl[g]),
      .in_val      (stage_val[g]),
      .in_res_val  (stage_rv[g]),
      .out_valid   (stage_valid[g+1]),
      .out_ctl     (stage_ctl[g+1]),
      .out_val     (stage_val[g+1]),
      .out_res_val (stage_rv[g+1])
    );
  end

  // Apply the count change of the request leaving the row
  assign count_next = count + CNT_W'(stage_ctl[SLOTS].inc) - CNT_W'(stage_ctl[SLOTS].dec);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= stage_valid[SLOTS];
      if (stage_valid[SLOTS]) begin
        count <= count_next;
      end
    end
  end

  // Hold the response payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= stage_ctl[SLOTS];
      out_val <= stage_rv[SLOTS];
      out_occ <= count_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_ctl.status;
  assign rsp.result_index = out_ctl.res_idx;
  assign rsp.result_value = RV_W'(out_val);
  assign rsp.occupied     = OC_W'(out_occ);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= SLOTS)
    else $error("occupied count beyond table size");

  a_add_ok_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_ctl.kind == ffst_pkg::KIND_ADD) && (out_ctl.status == ffst_pkg::ST_OK)
    |-> out_ctl.inc && !out_ctl.dec)
    else $error("successful add without count increment");

  a_del_only: assert property (@(posedge clk) disable iff (rst)
    stage_valid[SLOTS] && stage_ctl[SLOTS].dec |-> (stage_ctl[SLOTS].kind == ffst_pkg::KIND_DELETE)
    && (count != '0))
    else $error("count decrement outside a delete of an occupied slot");

  a_enter_row: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> stage_valid[0])
    else $error("accepted request missing at head of row");

endmodule

`default_nettype wire

// ===== bench/tb_first_free_slot_id_table_core.sv =====
`default_nettype none

module tb_first_free_slot_id_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ffst_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  // One expected response of the slot table
  typedef struct {
    status_t                 res_status;
    logic [SLOT_INDEX_W-1:0] res_slot;
    logic [VAL_W-1:0]        res_value;
    logic [OCC_W-1:0]        res_occupied;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst;

  ffst_req_if req_ch ();
  ffst_rsp_if rsp_ch ();
  ffst_cfg_if cfg_ch ();

  first_free_slot_id_table_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow copy of the table contents, count and capacity register
  logic [VAL_W-1:0]      slot_shadow [SLOTS_DEF];
  logic [OCC_W-1:0]      occupied_shadow;
  logic [CAPACITY_W-1:0] capacity_shadow;
  slot_result_t          pending_results [$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  steady_source = 1'b0;
  bit  steady_sink = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int slots_in_use();
    return (capacity_shadow > SLOTS_DEF) ? SLOTS_DEF : int'(capacity_shadow);
  endfunction

  // Apply one request to the shadow table and queue its response
  function automatic void predict_slot_op(kind_t kind, logic [SLOT_INDEX_W-1:0] slot,
                                          logic [VAL_W-1:0] value);
    slot_result_t r;
    int           cap;
    bit           placed;
    cap = slots_in_use();
    placed = 1'b0;
    r.res_status = ST_OK;
    r.res_slot = slot;
    r.res_value = '0;
    case (kind)
      KIND_ADD: begin
        if (value == '0) begin
          r.res_status = ST_BAD_VALUE;
        end else begin
          r.res_status = ST_FULL;
          for (int i = 0; i < cap; i++) begin
            if (!placed && slot_shadow[i] == '0) begin
              slot_shadow[i] = value;
              occupied_shadow = occupied_shadow + 1'b1;
              r.res_slot = SLOT_INDEX_W'(i);
              r.res_status = ST_OK;
              placed = 1'b1;
            end
          end
        end
      end
      KIND_LOOKUP, KIND_DELETE: begin
        if (int'(slot) >= cap) begin
          r.res_status = ST_BAD_INDEX;
        end else begin
          r.res_value = slot_shadow[slot];
          if (kind == KIND_DELETE && r.res_value != '0) begin
            slot_shadow[slot] = '0;
            occupied_shadow = occupied_shadow - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.res_occupied = occupied_shadow;
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t: response mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Send one request after a random gap; predict it at the accepting edge
  task automatic send_slot_request(kind_t kind, logic [SLOT_INDEX_W-1:0] slot,
                                   logic [VAL_W-1:0] value);
    int gap;
    gap = steady_source ? 0 : pick_idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.slot_index  <= slot;
    req_ch.entry_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_slot_op(kind, slot, value);
  endtask

  // Drop valid and wait for every outstanding response
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register with the table idle
  task automatic write_capacity(logic [CAPACITY_W-1:0] cap);
    drain_responses();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    capacity_shadow = cap;
    cfg_ch.valid <= 1'b0;
  endtask

  // Check each accepted response against the oldest expectation
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected response status", VAL_W'(rsp_ch.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.res_status)
          report_mismatch("status", VAL_W'(rsp_ch.status), VAL_W'(want.res_status));
        if (rsp_ch.result_index !== want.res_slot)
          report_mismatch("result_index", VAL_W'(rsp_ch.result_index), VAL_W'(want.res_slot));
        if (rsp_ch.result_value !== want.res_value)
          report_mismatch("result_value", rsp_ch.result_value, want.res_value);
        if (rsp_ch.occupied !== want.res_occupied)
          report_mismatch("occupied", VAL_W'(rsp_ch.occupied), VAL_W'(want.res_occupied));
      end
    end
  end

  // Stall the response side at random, with steady stretches
  initial begin
    int stall_left;
    int sink_cycles;
    stall_left = 0;
    sink_cycles = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if (sink_cycles % 400 == 0) steady_sink = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!steady_sink && $urandom_range(0, 2) == 0) stall_left = pick_idle_len();
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_first_free_slot_id_table_core failed");
        $finish;
      end
    end
  end

  // Empty table: lookups, delete of an empty slot, zero add, kind three
  task automatic test_empty_table();
    send_slot_request(KIND_LOOKUP, 6'd0, 32'hFFFF_FFFF);
    send_slot_request(KIND_LOOKUP, 6'd63, 32'h0);
    send_slot_request(KIND_DELETE, 6'd5, 32'h0);
    send_slot_request(KIND_ADD, 6'd63, 32'h0);
    send_slot_request(KIND_NOP, 6'd63, 32'hFFFF_FFFF);
  endtask

  // Fill, delete and refill the lowest free slot
  task automatic test_add_delete();
    send_slot_request(KIND_ADD, 6'd0, 32'hFFFF_FFFF);
    send_slot_request(KIND_ADD, 6'd63, 32'h0000_0001);
    send_slot_request(KIND_ADD, 6'd21, 32'h8000_0000);
    send_slot_request(KIND_DELETE, 6'd1, 32'hA5A5_A5A5);
    send_slot_request(KIND_ADD, 6'd42, 32'h1234_5678);
    send_slot_request(KIND_LOOKUP, 6'd2, 32'h0);
  endtask

  // Full table, zero capacity, saturating capacity, capacity below occupancy
  task automatic test_capacity_limits();
    write_capacity(7'd2);
    send_slot_request(KIND_ADD, 6'd0, 32'h0000_0005);
    send_slot_request(KIND_LOOKUP, 6'd2, 32'h0);
    send_slot_request(KIND_DELETE, 6'd63, 32'h0);
    write_capacity(7'd0);
    send_slot_request(KIND_ADD, 6'd0, 32'h0000_0007);
    send_slot_request(KIND_LOOKUP, 6'd0, 32'h0);
    write_capacity(7'd127);
    send_slot_request(KIND_LOOKUP, 6'd63, 32'h0);
    send_slot_request(KIND_ADD, 6'd0, 32'h0000_0009);
    write_capacity(7'd1);
    send_slot_request(KIND_DELETE, 6'd0, 32'h0);
    send_slot_request(KIND_ADD, 6'd0, 32'h0000_0055);
    send_slot_request(KIND_ADD, 6'd0, 32'h0000_0066);
    send_slot_request(KIND_LOOKUP, 6'd3, 32'h0);
  endtask

  function automatic logic [SLOT_INDEX_W-1:0] pick_slot();
    int q;
    int cap;
    q = $urandom_range(0, 9);
    cap = slots_in_use();
    if (q < 7 && cap > 0) return SLOT_INDEX_W'($urandom_range(0, cap - 1));
    if (q < 9) return SLOT_INDEX_W'($urandom_range(0, 63));
    return ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int q;
    q = $urandom_range(0, 19);
    if (q == 0) return '0;
    if (q == 1) return '1;
    if (q == 2) return 32'd1;
    return $urandom;
  endfunction

  // Random mix of adds, lookups and deletes, add-heavy or delete-heavy
  task automatic run_random_burst(int count, int add_pct);
    int    r;
    int    lookup_top;
    kind_t kind;
    lookup_top = add_pct + (96 - add_pct) / 2;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) steady_source = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < add_pct) kind = KIND_ADD;
      else if (r < lookup_top) kind = KIND_LOOKUP;
      else if (r < 96) kind = KIND_DELETE;
      else kind = KIND_NOP;
      if (kind == KIND_ADD) send_slot_request(kind, SLOT_INDEX_W'($urandom), pick_value());
      else send_slot_request(kind, pick_slot(), $urandom);
    end
    steady_source = 1'b0;
  endtask

  // Random traffic over several capacity settings
  task automatic test_random_traffic();
    int caps [8];
    int adds [8];
    caps = '{64, 64, 1, 2, 127, 0, 40, 64};
    adds = '{70, 25, 50, 50, 60, 40, 55, 50};
    caps[7] = $urandom_range(1, 64);
    for (int p = 0; p < 8; p++) begin
      write_capacity(CAPACITY_W'(caps[p]));
      run_random_burst(160, adds[p]);
    end
    write_capacity(CAPACITY_RESET);
    run_random_burst(40, 60);
  endtask

  initial begin
    for (int i = 0; i < SLOTS_DEF; i++) slot_shadow[i] = '0;
    occupied_shadow = '0;
    capacity_shadow = CAPACITY_RESET;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= KIND_ADD;
    req_ch.slot_index  <= '0;
    req_ch.entry_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_add_delete();
    test_capacity_limits();
    test_random_traffic();

    drain_responses();
    repeat (SLOTS_DEF + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_first_free_slot_id_table_core passed");
    end else begin
      $display("tb_first_free_slot_id_table_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/ffst_pkg.sv
design/ffst_req_if.sv
design/ffst_rsp_if.sv
design/ffst_cfg_if.sv
design/ffst_slot.sv
design/first_free_slot_id_table_core.sv
bench/tb_first_free_slot_id_table_core.sv
